// ===== rtl/rir_pkg.sv =====
package rir_pkg;

   localparam int MAX_LEVELS_DEF = 10;

   localparam int VW  = 48;   // Q8.40 value width
   localparam int QW  = VW + 1;
   localparam int HW  = 33;   // b - a, Q.28
   localparam int SW  = 64;   // sample sum width
   localparam int SHW = 6;    // product shift amount
   localparam int BW  = 32;   // bound register width

   localparam int FRAC_IN   = 28;
   localparam int RECIP_EXP = 68;
   localparam int T0_SHIFT  = 29;

   localparam logic signed [VW-1:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [QW-1:0] Q49_MAX = 49'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [QW-1:0] Q49_MIN = -49'sh0_7FFF_FFFF_FFFF;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DOMAIN = 2'd1;
   localparam logic [1:0] ST_SAT    = 2'd2;

   localparam logic CSR_LOWER = 1'b0;
   localparam logic CSR_UPPER = 1'b1;

   typedef struct packed {
      logic                 done;
      logic                 sat;
      logic signed [VW-1:0] val;
   } unit_res_type;

   function automatic logic signed [VW-1:0] clamp48(input logic signed [QW-1:0] v);
      logic signed [VW-1:0] r;
      if (v > Q49_MAX) begin
         r = Q48_MAX;
      end else if (v < Q49_MIN) begin
         r = -Q48_MAX;
      end else begin
         r = v[VW-1:0];
      end
      return r;
   endfunction

   function automatic logic over48(input logic signed [QW-1:0] v);
      return (v > Q49_MAX) || (v < Q49_MIN);
   endfunction

endpackage

// ===== rtl/rir_ram.sv =====
module rir_ram import rir_pkg::*; #(
   parameter int DEPTH = MAX_LEVELS_DEF + 1,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  logic signed [VW-1:0] wdata,
   input  logic [AW-1:0]        raddr,
   output logic signed [VW-1:0] rdata
);

   logic signed [VW-1:0] mem [DEPTH];
   logic signed [VW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rir_div.sv =====
// Restoring divider, one quotient bit per cycle, numerator bits top..0.
module rir_div import rir_pkg::*; #(
   parameter int NW = RECIP_EXP + MAX_LEVELS_DEF + 1,
   parameter int DW = 35 + MAX_LEVELS_DEF,
   parameter int PW = $clog2(NW)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          chk,      // stop and saturate above Q48_MAX
   input  logic [NW-1:0] num,
   input  logic [PW-1:0] top,
   input  logic [DW-1:0] den,
   output unit_res_type  res
);

   logic          run_ff, run_in;
   logic          chk_ff;
   logic [PW-1:0] p_ff;
   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] r_ff;
   logic [QW-1:0] q_ff;
   unit_res_type  res_ff, res_in;

   logic [DW:0]   rs;
   logic          ge;
   logic [DW:0]   rn;
   logic [QW-1:0] qn;

   always_comb begin
      rs = {r_ff, num_ff[p_ff]};
      ge = rs >= {1'b0, den_ff};
      rn = ge ? rs - {1'b0, den_ff} : rs;
      qn = {q_ff[QW-2:0], ge};
      run_in = run_ff;
      res_in = '0;
      res_in.val = res_ff.val;
      if (start) begin
         run_in = 1'b1;
      end else if (run_ff) begin
         if (chk_ff && (qn[QW-1:VW-1] != 2'b00)) begin
            run_in      = 1'b0;
            res_in.done = 1'b1;
            res_in.sat  = 1'b1;
            res_in.val  = Q48_MAX;
         end else if (p_ff == '0) begin
            run_in      = 1'b0;
            res_in.done = 1'b1;
            res_in.val  = qn[VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         res_ff.done <= 1'b0;
         res_ff.sat  <= 1'b0;
      end else begin
         run_ff      <= run_in;
         res_ff.done <= res_in.done;
         res_ff.sat  <= res_in.sat;
      end
      res_ff.val <= res_in.val;
      if (start) begin
         chk_ff <= chk;
         p_ff   <= top;
         num_ff <= num;
         den_ff <= den;
         r_ff   <= '0;
         q_ff   <= '0;
      end else if (run_ff) begin
         r_ff <= rn[DW-1:0];
         q_ff <= qn;
         p_ff <= p_ff - PW'(1);
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/rir_mul.sv =====
// trunc(h * s / 2^sh): two 32-bit partial products, then sum and shift.
module rir_mul import rir_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [HW-1:0]  h,
   input  logic [SW-1:0]         s,
   input  logic [SHW-1:0]        sh,
   output unit_res_type          res
);

   logic [1:0]     stage_ff, stage_in;
   logic [31:0]    m_ff;
   logic [SW-1:0]  s_ff;
   logic [SHW-1:0] sh_ff;
   logic           neg_ff;
   logic [63:0]    p0_ff, p1_ff;
   unit_res_type   res_ff, res_in;

   logic [HW-1:0]  habs;
   logic [95:0]    prod;
   logic [95:0]    sft;
   logic [VW-1:0]  mag;

   always_comb begin
      habs     = h[HW-1] ? HW'(-h) : HW'(h);
      prod     = {32'd0, p0_ff} + {p1_ff, 32'd0};
      sft      = prod >> sh_ff;
      stage_in = stage_ff;
      res_in   = '0;
      res_in.val = res_ff.val;
      mag      = '0;
      if (start) begin
         stage_in = 2'd1;
      end else if (stage_ff == 2'd3) begin
         stage_in    = 2'd0;
         res_in.done = 1'b1;
         if (sft > 96'(Q48_MAX)) begin
            res_in.sat = 1'b1;
            mag        = Q48_MAX;
         end else begin
            mag = sft[VW-1:0];
         end
         res_in.val = neg_ff ? -mag : mag;
      end else if (stage_ff != 2'd0) begin
         stage_in = stage_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= 2'd0;
         res_ff.done <= 1'b0;
         res_ff.sat  <= 1'b0;
      end else begin
         stage_ff    <= stage_in;
         res_ff.done <= res_in.done;
         res_ff.sat  <= res_in.sat;
      end
      res_ff.val <= res_in.val;
      if (start) begin
         m_ff   <= habs[31:0];
         s_ff   <= s;
         sh_ff  <= sh;
         neg_ff <= h[HW-1];
      end
      if (stage_ff == 2'd1) begin
         p0_ff <= m_ff * s_ff[31:0];
      end
      if (stage_ff == 2'd2) begin
         p1_ff <= m_ff * s_ff[63:32];
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/romberg_integrator_reciprocal.sv =====
// Romberg integration of 1/(1+x) over [lower_bound, upper_bound], one result per request.
// Each reciprocal is a bit-serial division; a request of k levels takes 2^k + 1 reciprocals
// plus k*(k+1)/2 extrapolation divides. One request is in flight; the next is taken when idle.
// Reset (synchronous, active high) clears control and restores the bounds to 0 and 1.0.
module romberg_integrator_reciprocal import rir_pkg::*; #(
   parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [3:0] levels
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata,   // [47:0] integral, [49:48] status
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [BW-1:0] csr_wdata
);

   // Derived sizes: sample point d needs 35+L bits, reciprocal numerator 2^(68+L).
   localparam int DW  = 35 + MAX_LEVELS;
   localparam int NW  = RECIP_EXP + MAX_LEVELS + 1;
   localparam int PW  = $clog2(NW);
   localparam int DEP = MAX_LEVELS + 1;
   localparam int AW  = (DEP > 1) ? $clog2(DEP) : 1;
   localparam int IW  = $clog2(MAX_LEVELS + 2);
   localparam int CW  = MAX_LEVELS;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_FA    = 5'd1;
   localparam logic [4:0] S_FAW   = 5'd2;
   localparam logic [4:0] S_FB    = 5'd3;
   localparam logic [4:0] S_FBW   = 5'd4;
   localparam logic [4:0] S_T0    = 5'd5;
   localparam logic [4:0] S_T0W   = 5'd6;
   localparam logic [4:0] S_LVL   = 5'd7;
   localparam logic [4:0] S_SMP   = 5'd8;
   localparam logic [4:0] S_SMPW  = 5'd9;
   localparam logic [4:0] S_RDP   = 5'd10;
   localparam logic [4:0] S_PMUL  = 5'd11;
   localparam logic [4:0] S_PMULW = 5'd12;
   localparam logic [4:0] S_XLOOP = 5'd13;
   localparam logic [4:0] S_XR1   = 5'd14;
   localparam logic [4:0] S_XR2   = 5'd15;
   localparam logic [4:0] S_XDIV  = 5'd16;
   localparam logic [4:0] S_XDIVW = 5'd17;
   localparam logic [4:0] S_OUT   = 5'd18;
   localparam logic [4:0] S_OUT2  = 5'd19;
   localparam logic [4:0] S_DONE  = 5'd20;

   // configuration registers
   logic signed [BW-1:0] lo_ff, hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= BW'(1) << FRAC_IN;
      end else if (csr_we) begin
         if (csr_index == CSR_LOWER) begin
            lo_ff <= csr_wdata;
         end else begin
            lo_ff <= lo_ff;
         end
         if (csr_index == CSR_UPPER) begin
            hi_ff <= csr_wdata;
         end
      end
   end

   // control and datapath registers
   logic [4:0]            state_ff, state_in;
   logic [IW-1:0]         k_ff, k_in;
   logic [IW-1:0]         ilev_ff, ilev_in;
   logic [IW-1:0]         j_ff, j_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic signed [HW-1:0]  h_ff, h_in;
   logic signed [DW-1:0]  d_ff, d_in;
   logic [SW-1:0]         sum_ff, sum_in;       // sample_sum
   logic signed [VW-1:0]  fa_ff, fa_in;
   logic signed [VW-1:0]  ta_ff, ta_in;
   logic signed [VW-1:0]  tb_ff, tb_in;
   logic                  sat_ff, sat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]  res_int_ff, res_int_in;
   logic [1:0]            res_st_ff, res_st_in;

   // unit handshakes
   logic                  div_start, div_chk;
   logic [NW-1:0]         div_num;
   logic [PW-1:0]         div_top;
   logic [DW-1:0]         div_den;
   unit_res_type          div_res;
   logic                  mul_start;
   logic [SW-1:0]         mul_s;
   logic [SHW-1:0]        mul_sh;
   unit_res_type          mul_res;

   // tableau memory port
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic signed [VW-1:0]  ram_wdata, ram_rdata;

   // combinational helpers
   logic signed [HW-1:0]  base_a, base_b;
   logic signed [DW-1:0]  d_first;
   logic signed [QW-1:0]  half_prev, tnew, diff, qs, xnew;
   logic [QW-1:0]         dabs;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      base_a    = HW'(lo_ff) + (HW'(1) <<< FRAC_IN);
      base_b    = HW'(hi_ff) + (HW'(1) <<< FRAC_IN);
      // first midpoint of level i: (1 + a) * 2^i + h
      d_first   = (DW'(base_a) <<< ilev_ff) + DW'(h_ff);
      // trunc(T(i-1) / 2) toward zero
      half_prev = (QW'(ta_ff) + $signed(QW'(ta_ff < 0))) >>> 1;
      tnew      = half_prev + QW'(mul_res.val);
      diff      = QW'(tb_ff) - QW'(ta_ff);
      dabs      = diff[QW-1] ? QW'(-diff) : QW'(diff);
      qs        = diff[QW-1] ? -QW'(div_res.val) : QW'(div_res.val);
      xnew      = QW'(tb_ff) + qs;

      state_in     = state_ff;
      k_in         = k_ff;
      ilev_in      = ilev_ff;
      j_in         = j_ff;
      cnt_in       = cnt_ff;
      h_in         = h_ff;
      d_in         = d_ff;
      sum_in       = sum_ff;
      fa_in        = fa_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      sat_in       = sat_ff;
      res_int_in   = res_int_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      div_start = 1'b0;
      div_chk   = 1'b1;
      div_num   = NW'(1) << (RECIP_EXP + 32'(ilev_ff));
      div_top   = PW'(RECIP_EXP + 32'(ilev_ff));
      div_den   = DW'(d_ff);
      mul_start = 1'b0;
      mul_s     = sum_ff;
      mul_sh    = SHW'(FRAC_IN + 32'(ilev_ff));
      ram_we    = 1'b0;
      ram_waddr = AW'(ilev_ff);
      ram_wdata = clamp48(tnew);
      ram_raddr = AW'(ilev_ff - IW'(1));

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (32'(req_tdata[3:0]) > MAX_LEVELS) begin
                  k_in = IW'(MAX_LEVELS);
               end else begin
                  k_in = IW'(req_tdata[3:0]);
               end
               h_in     = HW'(hi_ff) - HW'(lo_ff);
               sat_in   = 1'b0;
               state_in = S_FA;
            end
         end
         S_FA: begin
            d_in = DW'(base_a);
            if (base_a <= 0) begin
               state_in = S_DONE;
               res_int_in = '0;
               res_st_in  = ST_DOMAIN;
            end else begin
               state_in = S_FAW;
            end
         end
         S_FAW, S_FBW, S_SMPW: begin
            // divide was issued by the state before; wait for its result
            if (div_res.done) begin
               sat_in = sat_ff | div_res.sat;
               if (state_ff == S_FAW) begin
                  fa_in    = div_res.val;
                  state_in = S_FB;
               end else if (state_ff == S_FBW) begin
                  sum_in   = SW'(fa_ff) + SW'(div_res.val);
                  state_in = S_T0;
               end else begin
                  sum_in = sum_ff + SW'(div_res.val);
                  cnt_in = cnt_ff + CW'(1);
                  d_in   = d_ff + (DW'(h_ff) <<< 1);
                  if ((cnt_ff + CW'(1)) == (CW'(1) << (ilev_ff - IW'(1)))) begin
                     state_in = S_RDP;
                  end else begin
                     state_in = S_SMP;
                  end
               end
            end
         end
         S_FB: begin
            d_in = DW'(base_b);
            if (base_b <= 0) begin
               state_in   = S_DONE;
               res_int_in = '0;
               res_st_in  = ST_DOMAIN;
            end else begin
               state_in = S_FBW;
            end
         end
         S_T0: begin
            mul_start = 1'b1;
            mul_sh    = SHW'(T0_SHIFT);
            state_in  = S_T0W;
         end
         S_T0W: begin
            if (mul_res.done) begin
               sat_in    = sat_ff | mul_res.sat;
               ram_we    = 1'b1;
               ram_waddr = '0;
               ram_wdata = mul_res.val;
               ilev_in   = IW'(1);
               state_in  = S_LVL;
            end
         end
         S_LVL: begin
            if (ilev_ff > k_ff) begin
               ilev_in  = IW'(1);
               j_in     = '0;
               state_in = S_XLOOP;
            end else begin
               d_in     = d_first;
               cnt_in   = '0;
               sum_in   = '0;
               state_in = S_SMP;
            end
         end
         S_SMP: begin
            if (d_ff <= 0) begin
               state_in   = S_DONE;
               res_int_in = '0;
               res_st_in  = ST_DOMAIN;
            end else begin
               state_in = S_SMPW;
            end
         end
         S_RDP: begin
            // read T(i-1); data valid next cycle
            state_in = S_PMUL;
         end
         S_PMUL: begin
            ta_in     = ram_rdata;
            mul_start = 1'b1;
            state_in  = S_PMULW;
         end
         S_PMULW: begin
            if (mul_res.done) begin
               sat_in   = sat_ff | mul_res.sat | over48(tnew);
               ram_we   = 1'b1;
               ilev_in  = ilev_ff + IW'(1);
               state_in = S_LVL;
            end
         end
         S_XLOOP: begin
            ram_raddr = AW'(j_ff + IW'(1));
            if (ilev_ff > k_ff) begin
               state_in = S_OUT;
            end else if ((j_ff + ilev_ff) > k_ff) begin
               ilev_in = ilev_ff + IW'(1);
               j_in    = '0;
            end else begin
               state_in = S_XR1;
            end
         end
         S_XR1: begin
            tb_in     = ram_rdata;
            ram_raddr = AW'(j_ff);
            state_in  = S_XR2;
         end
         S_XR2: begin
            ta_in    = ram_rdata;
            state_in = S_XDIV;
         end
         S_XDIV: begin
            div_start = 1'b1;
            div_chk   = 1'b0;
            div_num   = NW'(dabs);
            div_top   = PW'(QW - 1);
            div_den   = (DW'(1) << (2 * 32'(ilev_ff))) - DW'(1);
            state_in  = S_XDIVW;
         end
         S_XDIVW: begin
            if (div_res.done) begin
               sat_in    = sat_ff | over48(xnew);
               ram_we    = 1'b1;
               ram_waddr = AW'(j_ff);
               ram_wdata = clamp48(xnew);
               j_in      = j_ff + IW'(1);
               state_in  = S_XLOOP;
            end
         end
         S_OUT: begin
            ram_raddr = '0;
            state_in  = S_OUT2;
         end
         S_OUT2: begin
            res_int_in = ram_rdata;
            res_st_in  = sat_ff ? ST_SAT : ST_OK;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // reciprocal divides start on entry to a wait state
      if ((state_ff == S_FA && base_a > 0) || (state_ff == S_FB && base_b > 0) ||
          (state_ff == S_SMP && d_ff > 0)) begin
         div_start = 1'b1;
      end
      if (state_ff == S_FA) begin
         div_num = NW'(1) << RECIP_EXP;
         div_top = PW'(RECIP_EXP);
         div_den = DW'(base_a);
      end else if (state_ff == S_FB) begin
         div_num = NW'(1) << RECIP_EXP;
         div_top = PW'(RECIP_EXP);
         div_den = DW'(base_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff    <= k_in;
      ilev_ff <= ilev_in;
      j_ff    <= j_in;
      cnt_ff  <= cnt_in;
      h_ff    <= h_in;
      d_ff    <= d_in;
      sum_ff  <= sum_in;
      fa_ff   <= fa_in;
      ta_ff   <= ta_in;
      tb_ff   <= tb_in;
      sat_ff  <= sat_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         res_int_ff <= res_int_in;
         res_st_ff  <= res_st_in;
      end else begin
         res_int_ff <= res_int_in;
         res_st_ff  <= res_st_in;
      end
   end

   // output holding register: loaded only when the result slot is free
   logic signed [VW-1:0] out_int_ff;
   logic [1:0]           out_st_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         out_int_ff <= res_int_ff;
         out_st_ff  <= res_st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_st_ff, out_int_ff};

   // tableau memory: one access per cycle by sequencing, no same-entry overlap
   rir_ram #(
      .DEPTH (DEP),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared divider: reciprocals and extrapolation quotients
   rir_div #(
      .NW (NW),
      .DW (DW),
      .PW (PW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .chk   (div_chk),
      .num   (div_num),
      .top   (div_top),
      .den   (div_den),
      .res   (div_res)
   );

   rir_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .h     (h_ff),
      .s     (mul_s),
      .sh    (mul_sh),
      .res   (mul_res)
   );

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_res.done |-> (state_ff == S_T0W || state_ff == S_PMULW))
      else $error("multiplier finished outside a product wait");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[49:48] != 2'd3))
      else $error("undefined status code");

   a_domain_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[49:48] == ST_DOMAIN) |-> (rsp_tdata[47:0] == 48'd0))
      else $error("domain error with nonzero integral");
`endif

endmodule
